// ===== rtl/core/brbs_pkg.sv =====
// Shared types and constants for the byte ring buffer with spans.
package brbs_pkg;

    // Operation codes carried in the operation field of an input word.
    typedef enum logic [2:0] {
        OP_WRITE      = 3'd0,
        OP_READ       = 3'd1,
        OP_WSPAN      = 3'd2,
        OP_WCOMMIT    = 3'd3,
        OP_RSPAN      = 3'd4,
        OP_RCOMMIT    = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    // Bytes per data word and the widths that follow from it.
    localparam int WORD_BYTES  = 8;
    localparam int LANE_W      = 3;   // byte lane index within a data word
    localparam int BYTE_CNT_W  = 4;   // holds 0 .. WORD_BYTES

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  count;
        logic [63:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [63:0] read_data;
        logic [6:0]  span_offset;
        logic [7:0]  span_length;
        logic [7:0]  fill_level;
        logic        is_empty;
    } t_out_word;

endpackage

// ===== rtl/core/byte_ring_buffer_with_spans_unit.sv =====
// Byte ring buffer with free-running counters, byte-serial store access and span queries.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) carries one operation per word:
//   write, read, write span query, write commit, read span query, read commit, clear.
//   Output channel (o_out_valid / i_out_ready / o_out_word) returns one result word per
//   input word, in order.
//   The byte store is one byte-wide synchronous RAM with a registered read port.
//   Writes and reads walk the RAM one byte per cycle, so the cost of an item is set by
//   that single RAM port. An accepted write of n bytes (n > 0) steps through n write
//   states, then the done state; an accepted read of n bytes (n > 0) steps through n read
//   states, a drain state for the registered RAM output, then the done state. Queries,
//   commits, clear, zero-byte items and refusals go from accept straight to the done state.
//   With a free output register the result word turns valid as the engine leaves done.
//   The result is loaded into an output register; the engine takes the next input word
//   while that result waits. A stalled receiver holds the output register, and once the
//   next result is finished the engine waits for it to drain before taking more input.
//   Reset (synchronous, active low) zeroes both counters and drops any pending result;
//   RAM contents are left as they are and are undefined until written.
module byte_ring_buffer_with_spans_unit #(
    parameter int DEPTH     = 128,
    parameter int MAX_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  brbs_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output brbs_pkg::t_out_word   o_out_word
);
    import brbs_pkg::*;

    localparam int AW = $clog2(DEPTH);          // store address width
    localparam int CW = AW + 1;                 // counters run modulo 2*DEPTH
    localparam int LW = (CW > 8) ? CW : 8;      // common width for length compares
    localparam int OW = (AW > 7) ? AW : 7;      // common width for offset output

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    // Control state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_wc, n_wc;
    logic [CW-1:0]        r_rc, n_rc;
    logic                 r_out_valid, n_out_valid;
    logic                 r_cap_pend, n_cap_pend;

    // Payload and sequencing registers
    logic [AW-1:0]        r_addr, n_addr;
    logic [BYTE_CNT_W-1:0] r_left, n_left;
    logic [LANE_W-1:0]    r_idx, n_idx;
    logic [LANE_W-1:0]    r_cap_slot, n_cap_slot;
    logic [63:0]          r_wdata, n_wdata;
    logic [63:0]          r_rdata;
    t_out_word            r_res, n_res;
    t_out_word            r_out_word, n_out_word;

    // Byte store
    logic [7:0]           r_mem [DEPTH];
    logic [7:0]           r_mem_q;
    logic                 mem_we;
    logic                 mem_re;

    // Decision for the word at the input
    logic                 in_acc;
    logic                 out_free;
    logic [AW-1:0]        wp, rp;
    logic [CW-1:0]        held_w, free_w;
    logic [LW-1:0]        cnt_ext;
    logic                 cnt_small;
    logic                 fits_free, fits_held;
    logic [CW-1:0]        wspan_len, rspan_len;
    logic [LW-1:0]        wspan_ext, rspan_ext;
    logic [OW-1:0]        wp_ext, rp_ext;
    logic                 d_ok;
    logic [6:0]           d_off;
    logic [7:0]           d_len;
    logic [CW-1:0]        d_wc, d_rc;
    logic [CW-1:0]        d_held;
    logic [LW-1:0]        d_held_ext;
    t_state               d_next;
    logic [AW-1:0]        d_addr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Positions in the store and the occupancy they imply
    assign wp        = r_wc[AW-1:0];
    assign rp        = r_rc[AW-1:0];
    assign held_w    = r_wc - r_rc;
    assign free_w    = CW'(DEPTH) - held_w;
    assign cnt_ext   = LW'(i_in_word.count);
    assign cnt_small = (i_in_word.count <= 8'(MAX_BYTES));
    assign fits_free = (cnt_ext <= LW'(free_w));
    assign fits_held = (cnt_ext <= LW'(held_w));

    // Write span stops one byte short of the store end when wp is at or past rp
    assign wspan_len = (wp >= rp) ? (CW'(DEPTH - 1) - CW'(wp)) : (CW'(rp) - CW'(wp));
    assign rspan_len = (wp > rp)  ? (CW'(wp) - CW'(rp))        : (CW'(DEPTH) - CW'(rp));
    assign wspan_ext = LW'(wspan_len);
    assign rspan_ext = LW'(rspan_len);
    assign wp_ext    = OW'(wp);
    assign rp_ext    = OW'(rp);

    always_comb begin
        d_ok   = 1'b0;
        d_off  = '0;
        d_len  = '0;
        d_wc   = r_wc;
        d_rc   = r_rc;
        d_next = S_DONE;
        d_addr = wp;
        case (i_in_word.operation)
            OP_WRITE: begin
                if (cnt_small && fits_free) begin
                    d_ok = 1'b1;
                    d_wc = r_wc + CW'(i_in_word.count);
                    if (i_in_word.count != 8'd0) begin
                        d_next = S_WRITE;
                    end
                end
            end
            OP_READ: begin
                d_addr = rp;
                if (cnt_small && fits_held) begin
                    d_ok = 1'b1;
                    d_rc = r_rc + CW'(i_in_word.count);
                    if (i_in_word.count != 8'd0) begin
                        d_next = S_READ;
                    end
                end
            end
            OP_WSPAN: begin
                if (free_w != '0) begin
                    d_ok  = 1'b1;
                    d_off = wp_ext[6:0];
                    d_len = wspan_ext[7:0];
                end
            end
            OP_WCOMMIT: begin
                if (fits_free) begin
                    d_ok = 1'b1;
                    d_wc = r_wc + CW'(i_in_word.count);
                end
            end
            OP_RSPAN: begin
                if (held_w != '0) begin
                    d_ok  = 1'b1;
                    d_off = rp_ext[6:0];
                    d_len = rspan_ext[7:0];
                end
            end
            OP_RCOMMIT: begin
                if (fits_held) begin
                    d_ok = 1'b1;
                    d_rc = r_rc + CW'(i_in_word.count);
                end
            end
            OP_CLEAR: begin
                d_ok = 1'b1;
                d_wc = '0;
                d_rc = '0;
            end
            default: begin
                // unused code: refuse, change nothing
            end
        endcase
    end

    assign d_held     = d_wc - d_rc;
    assign d_held_ext = LW'(d_held);

    // Sequencer: commit counters at accept, then walk the store one byte per cycle
    always_comb begin
        n_state     = r_state;
        n_wc        = r_wc;
        n_rc        = r_rc;
        n_addr      = r_addr;
        n_left      = r_left;
        n_idx       = r_idx;
        n_wdata     = r_wdata;
        n_res       = r_res;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cap_pend  = 1'b0;
        n_cap_slot  = r_idx;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = d_next;
                    n_wc    = d_wc;
                    n_rc    = d_rc;
                    n_addr  = d_addr;
                    n_left  = i_in_word.count[BYTE_CNT_W-1:0];
                    n_idx   = '0;
                    n_wdata = i_in_word.write_data;
                    n_res   = '{ok:          d_ok,
                                read_data:   64'd0,
                                span_offset: d_off,
                                span_length: d_len,
                                fill_level:  d_held_ext[7:0],
                                is_empty:    (d_wc == d_rc)};
                end
            end
            S_WRITE: begin
                mem_we  = 1'b1;
                n_addr  = r_addr + 1'b1;
                n_wdata = r_wdata >> 8;
                n_left  = r_left - 1'b1;
                if (r_left == BYTE_CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                mem_re     = 1'b1;
                n_cap_pend = 1'b1;
                n_addr     = r_addr + 1'b1;
                n_idx      = r_idx + 1'b1;
                n_left     = r_left - 1'b1;
                if (r_left == BYTE_CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last byte lands in r_rdata at this edge
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_word           = r_res;
                    n_out_word.read_data = r_rdata;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wc        <= '0;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
            r_cap_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wc        <= n_wc;
            r_rc        <= n_rc;
            r_out_valid <= n_out_valid;
            r_cap_pend  <= n_cap_pend;
        end
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_idx      <= n_idx;
        r_cap_slot <= n_cap_slot;
        r_wdata    <= n_wdata;
        r_res      <= n_res;
        r_out_word <= n_out_word;
        if (in_acc) begin
            r_rdata <= '0;
        end else if (r_cap_pend) begin
            r_rdata[{r_cap_slot, 3'b000} +: 8] <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= r_wdata[7:0];
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_addr];
        end
    end

    // Occupancy never exceeds the store size
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(held_w) <= LW'(DEPTH))
        else $error("occupancy above store size");

    // A byte capture is only pending while a read walks the store
    a_cap_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_pend |-> (r_state == S_READ || r_state == S_DRAIN))
        else $error("read capture outside read sequence");

    // Byte walks never run with nothing left to move
    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE || r_state == S_READ) |-> (r_left != '0))
        else $error("byte walk with zero bytes left");

    // A finished result reaches the output register as soon as it is free
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not delivered");

endmodule

// ===== test/tb_byte_ring_buffer_with_spans_unit.sv =====
// Self-checking testbench for the byte ring buffer with spans.
`timescale 1ns / 100ps

module tb_byte_ring_buffer_with_spans_unit;
    import brbs_pkg::*;

    localparam int DEPTH          = 128;
    localparam int MAX_BYTES      = 8;
    localparam int RANDOM_WORDS   = 1175;
    localparam int HOLD_OFF_AFTER = 400;     // input words accepted before the long stall
    localparam int HOLD_OFF_LEN   = 300;     // cycles the receiver refuses results
    localparam int DRAIN_CYCLES   = 32;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int N_DIRECTED     = 25;

    // The operation field is 3 bits wide; the one code the package leaves unnamed.
    localparam logic [2:0]  OP_UNUSED = 3'd7;
    localparam logic [63:0] ALL_ONES  = {64{1'b1}};

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       o_in_ready;
    t_in_word   in_word;
    logic       o_out_valid;
    logic       out_ready;
    t_out_word  o_out_word;

    byte_ring_buffer_with_spans_unit #(
        .DEPTH     (DEPTH),
        .MAX_BYTES (MAX_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the ring: counters run modulo 2*DEPTH, which is
    // exactly the 8-bit wrap, so plain 8-bit arithmetic keeps them right.
    // byte_written tracks which store entries hold defined data, so the
    // stimulus never reads a byte that only a write commit skipped over.
    // ------------------------------------------------------------------
    logic [7:0] ring_bytes   [0:DEPTH-1];
    bit         byte_written [0:DEPTH-1];
    logic [7:0] wr_ctr;
    logic [7:0] rd_ctr;

    t_out_word  pending_results [$];
    t_in_word   last_word;
    t_out_word  last_result;

    int         failures;
    int         words_accepted;
    int         results_checked;
    int         op_seen [0:7];
    int         refused_seen;
    bit         sender_steady;

    // Directed rows: where the expected word is obvious (reset state,
    // refusals, extremes) it is typed in; other rows use the shadow model.
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  cnt;
        logic [63:0] data;
        logic        typed;
        logic        ok;
        logic [63:0] rdata;
        logic [7:0]  fill;
        logic        empty;
    } t_dir_row;

    t_dir_row directed_rows [0:N_DIRECTED-1] = '{
        // empty buffer: query and read both refused
        '{OP_RSPAN,   8'd0,   64'd0,                 1'b1, 1'b0, 64'd0,    8'd0,   1'b1},
        '{OP_READ,    8'd1,   64'd0,                 1'b1, 1'b0, 64'd0,    8'd0,   1'b1},
        // oversized write, then a zero-byte write
        '{OP_WRITE,   8'd9,   ALL_ONES,              1'b1, 1'b0, 64'd0,    8'd0,   1'b1},
        '{OP_WRITE,   8'd0,   ALL_ONES,              1'b1, 1'b1, 64'd0,    8'd0,   1'b1},
        // full-width write and read of all ones
        '{OP_WRITE,   8'd8,   ALL_ONES,              1'b1, 1'b1, 64'd0,    8'd8,   1'b0},
        '{OP_READ,    8'd8,   64'd0,                 1'b1, 1'b1, ALL_ONES, 8'd0,   1'b1},
        '{OP_WRITE,   8'd8,   64'd0,                 1'b1, 1'b1, 64'd0,    8'd8,   1'b0},
        '{OP_WSPAN,   8'd0,   64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        '{OP_RSPAN,   8'd0,   64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        // commit past the free space, then fill the buffer exactly
        '{OP_WCOMMIT, 8'd129, 64'd0,                 1'b1, 1'b0, 64'd0,    8'd8,   1'b0},
        '{OP_WCOMMIT, 8'd120, 64'd0,                 1'b1, 1'b1, 64'd0,    8'd128, 1'b0},
        // full buffer: write query and write refused
        '{OP_WSPAN,   8'd0,   64'd0,                 1'b1, 1'b0, 64'd0,    8'd128, 1'b0},
        '{OP_WRITE,   8'd1,   64'hA5,                1'b1, 1'b0, 64'd0,    8'd128, 1'b0},
        '{OP_RSPAN,   8'd0,   64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        '{OP_RCOMMIT, 8'd255, 64'd0,                 1'b1, 1'b0, 64'd0,    8'd128, 1'b0},
        '{OP_READ,    8'd8,   64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        '{OP_RCOMMIT, 8'd120, 64'd0,                 1'b1, 1'b1, 64'd0,    8'd0,   1'b1},
        // unused code is ignored
        '{OP_UNUSED,  8'd255, ALL_ONES,              1'b1, 1'b0, 64'd0,    8'd0,   1'b1},
        '{OP_CLEAR,   8'd0,   64'd0,                 1'b1, 1'b1, 64'd0,    8'd0,   1'b1},
        // park both counters on the last byte: write span of length zero
        '{OP_WCOMMIT, 8'd127, 64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        '{OP_RCOMMIT, 8'd127, 64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        '{OP_WSPAN,   8'd0,   64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        // write and read that wrap around the end of the store
        '{OP_WRITE,   8'd8,   64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'd0,  8'd0,   1'b0},
        '{OP_READ,    8'd8,   64'd0,                 1'b0, 1'b0, 64'd0,    8'd0,   1'b0},
        '{OP_CLEAR,   8'd0,   64'd0,                 1'b1, 1'b1, 64'd0,    8'd0,   1'b1}
    };

    // Apply one input word to the shadow ring and work out its result word.
    task automatic predict_ring_op(input t_in_word w, output t_out_word r);
        logic [7:0] diff;
        int         held;
        int         room;
        int         wp;
        int         rp;
        int         n;
        diff = wr_ctr - rd_ctr;
        held = int'(diff);
        room = DEPTH - held;
        wp   = int'(wr_ctr[6:0]);
        rp   = int'(rd_ctr[6:0]);
        n    = int'(w.count);
        r    = '0;
        case (w.operation)
            OP_WRITE: begin
                if (n <= MAX_BYTES && n <= room) begin
                    for (int i = 0; i < n; i++) begin
                        ring_bytes[7'(wp + i)]   = w.write_data[8*i +: 8];
                        byte_written[7'(wp + i)] = 1'b1;
                    end
                    wr_ctr = wr_ctr + 8'(n);
                    r.ok   = 1'b1;
                end
            end
            OP_READ: begin
                if (n <= MAX_BYTES && n <= held) begin
                    for (int i = 0; i < n; i++)
                        r.read_data[8*i +: 8] = ring_bytes[7'(rp + i)];
                    rd_ctr = rd_ctr + 8'(n);
                    r.ok   = 1'b1;
                end
            end
            OP_WSPAN: begin
                if (room != 0) begin
                    // span stops one byte short of the store end when wp >= rp
                    r.span_offset = 7'(wp);
                    r.span_length = 8'((wp >= rp) ? DEPTH - wp - 1 : rp - wp);
                    r.ok          = 1'b1;
                end
            end
            OP_WCOMMIT: begin
                if (n <= room) begin
                    wr_ctr = wr_ctr + 8'(n);
                    r.ok   = 1'b1;
                end
            end
            OP_RSPAN: begin
                if (held != 0) begin
                    r.span_offset = 7'(rp);
                    r.span_length = 8'((wp > rp) ? wp - rp : DEPTH - rp);
                    r.ok          = 1'b1;
                end
            end
            OP_RCOMMIT: begin
                if (n <= held) begin
                    rd_ctr = rd_ctr + 8'(n);
                    r.ok   = 1'b1;
                end
            end
            OP_CLEAR: begin
                wr_ctr = '0;
                rd_ctr = '0;
                r.ok   = 1'b1;
            end
            default: ;
        endcase
        r.fill_level = wr_ctr - rd_ctr;
        r.is_empty   = (wr_ctr == rd_ctr);
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Commit sizes cluster on the boundary: exactly the limit, one past it.
    function automatic logic [7:0] commit_count(input int lim);
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 16));
            1:       return 8'(lim);
            2:       return 8'(lim + 1);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_word next_random_word();
        t_in_word   w;
        logic [7:0] diff;
        int         held;
        int         room;
        int         r;
        int         rp;
        bit         hole;
        diff = wr_ctr - rd_ctr;
        held = int'(diff);
        room = DEPTH - held;
        w            = '0;
        w.write_data = {$urandom, $urandom};
        w.count      = 8'($urandom_range(0, MAX_BYTES));
        r            = $urandom_range(0, 99);
        // Follow a successful span query with a commit inside that span.
        if (last_result.ok && last_word.operation == OP_WSPAN && r < 75) begin
            w.operation = OP_WCOMMIT;
            w.count     = 8'($urandom_range(0, last_result.span_length));
        end else if (last_result.ok && last_word.operation == OP_RSPAN && r < 75) begin
            w.operation = OP_RCOMMIT;
            w.count     = 8'($urandom_range(0, last_result.span_length));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                // lean toward writes when nearly empty, reads when nearly full
                w.operation = ($urandom_range(0, DEPTH - 1) >= held) ? OP_WRITE : OP_READ;
                if ($urandom_range(0, 19) == 0)
                    w.count = 8'($urandom_range(MAX_BYTES + 1, 255));
            end else if (r < 69) begin
                w.operation = OP_WSPAN;
            end else if (r < 76) begin
                w.operation = OP_RSPAN;
            end else if (r < 82) begin
                w.operation = OP_WCOMMIT;
                w.count     = commit_count(room);
            end else if (r < 88) begin
                w.operation = OP_RCOMMIT;
                w.count     = commit_count(held);
            end else if (r < 91) begin
                w.operation = OP_CLEAR;
            end else if (r < 94) begin
                w.operation = OP_UNUSED;
                w.count     = 8'($urandom_range(0, 255));
            end else begin
                w.operation = 3'($urandom_range(0, 7));
                w.count     = 8'($urandom_range(0, 255));
            end
        end
        // Turn a read that would touch never-written bytes into a read commit.
        if (w.operation == OP_READ && w.count <= MAX_BYTES && w.count <= held) begin
            rp   = int'(rd_ctr[6:0]);
            hole = 1'b0;
            for (int i = 0; i < w.count; i++)
                if (!byte_written[7'(rp + i)])
                    hole = 1'b1;
            if (hole)
                w.operation = OP_RCOMMIT;
        end
        return w;
    endfunction

    // Offer one word, hold it until accepted, then queue its expected result.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_result);
        t_out_word pred;
        int        gap;
        gap = idle_len(sender_steady);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_ring_op(w, pred);
        pending_results.push_back(typed ? typed_result : pred);
        last_word   = w;
        last_result = pred;
        words_accepted++;
        op_seen[w.operation]++;
        if (!pred.ok)
            refused_seen++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and the hard stop.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check every accepted result word against the oldest
    // expectation, stall at random, and once hold off for a long stretch
    // so the block backs up and drops o_in_ready.
    // ------------------------------------------------------------------
    initial begin : result_side
        t_out_word want;
        int        stall;
        int        mode_left;
        bit        steady;
        bit        hold_done;
        stall     = 0;
        mode_left = 0;
        steady    = 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation waiting: %h", o_out_word);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("ok",          64'(want.ok),          64'(o_out_word.ok));
                    check_field("read_data",   want.read_data,        o_out_word.read_data);
                    check_field("span_offset", 64'(want.span_offset),
                                64'(o_out_word.span_offset));
                    check_field("span_length", 64'(want.span_length),
                                64'(o_out_word.span_length));
                    check_field("fill_level",  64'(want.fill_level),
                                64'(o_out_word.fill_level));
                    check_field("is_empty",    64'(want.is_empty),    64'(o_out_word.is_empty));
                    results_checked++;
                end
            end
            // switch between stall-free stretches and random stalls
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = 64;
            end
            mode_left--;
            if (!hold_done && words_accepted >= HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                stall     = HOLD_OFF_LEN;
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                stall = idle_len(steady);
                out_ready <= (stall == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: reset, the directed table, then random words.
    // ------------------------------------------------------------------
    initial begin : input_side
        t_in_word  w;
        t_out_word typed_result;
        int        random_done;
        failures        = 0;
        words_accepted  = 0;
        results_checked = 0;
        refused_seen    = 0;
        sender_steady   = 1'b0;
        wr_ctr          = '0;
        rd_ctr          = '0;
        last_word       = '0;
        last_result     = '0;
        foreach (op_seen[k])
            op_seen[k] = 0;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        for (int k = 0; k < N_DIRECTED; k++) begin
            w                        = '0;
            w.operation              = directed_rows[k].op;
            w.count                  = directed_rows[k].cnt;
            w.write_data             = directed_rows[k].data;
            typed_result             = '0;
            typed_result.ok          = directed_rows[k].ok;
            typed_result.read_data   = directed_rows[k].rdata;
            typed_result.fill_level  = directed_rows[k].fill;
            typed_result.is_empty    = directed_rows[k].empty;
            send_word(w, directed_rows[k].typed, typed_result);
        end

        // Random words; the unused code does not count toward the total.
        random_done = 0;
        while (random_done < RANDOM_WORDS) begin
            if (random_done % 40 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            w = next_random_word();
            send_word(w, 1'b0, '0);
            if (w.operation != OP_UNUSED)
                random_done++;
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d words (%0d refused) and checked %0d results.",
                 words_accepted, refused_seen, results_checked);
        $display("Per op: wr %0d rd %0d wspan %0d wcommit %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("        rspan %0d rcommit %0d clr %0d unused %0d",
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
